// ----- hw/rtl/mru_pkg.sv -----
package mru_pkg;

    // Grid geometry and word widths.
    localparam int DIMS      = 4;
    localparam int NUM_DIV   = DIMS - 1;
    localparam int IDX_W     = 32;
    localparam int SIZE_W    = 8;
    localparam int SEL_W     = 2;
    localparam int ORDER_W   = DIMS * SEL_W;
    localparam int STRIDE_W  = 24;
    localparam int PROD2_W   = 2 * SIZE_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [SIZE_W-1:0]   SIZE_RESET  = 8'd16;
    localparam logic [ORDER_W-1:0]  ORDER_RESET = 8'd228;
    localparam logic [PROD2_W-1:0]  PROD2_RESET = 16'd256;
    localparam logic [STRIDE_W-1:0] PROD3_RESET = 24'd4096;
    localparam logic [IDX_W-1:0]    GRID_RESET  = 32'd65536;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_SIZE_0,
        REG_DIM_SIZE_1,
        REG_DIM_SIZE_2,
        REG_DIM_SIZE_3,
        REG_PEEL_ORDER
    } cfg_reg_t;

    // One word moving through the division pipeline.
    typedef struct packed {
        logic [IDX_W-1:0]                idx;
        logic [IDX_W-1:0]                num;
        logic [STRIDE_W-1:0]             rem;
        logic [IDX_W-1:0]                quo;
        logic [NUM_DIV-1:0][IDX_W-1:0]   qlist;
    } word_t;

    // Geometry derived from the configuration registers.
    typedef struct packed {
        logic [DIMS-1:0][STRIDE_W-1:0] stride;
        logic [IDX_W-1:0]              grid;
        logic [DIMS-1:0][SEL_W-1:0]    sel;
    } geom_t;

endpackage

// ----- hw/rtl/mru_cfg.sv -----
module mru_cfg
    import mru_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output geom_t                geom
);

    logic [DIMS-1:0][SIZE_W-1:0] size_reg;
    logic [ORDER_W-1:0]          order_reg;
    logic [PROD2_W-1:0]          prod2_reg, prod2_next;
    logic [STRIDE_W-1:0]         prod3_reg, prod3_next;
    logic [IDX_W-1:0]            grid_reg, grid_next;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DIMS; d++) begin
                size_reg[d] <= SIZE_RESET;
            end
            order_reg <= ORDER_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIM_SIZE_0: size_reg[0] <= cfg_data;
                REG_DIM_SIZE_1: size_reg[1] <= cfg_data;
                REG_DIM_SIZE_2: size_reg[2] <= cfg_data;
                REG_DIM_SIZE_3: size_reg[3] <= cfg_data;
                REG_PEEL_ORDER: order_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Prefix products, one multiplier per register, chained through prod2_reg, prod3_reg, grid_reg.
    assign prod2_next = PROD2_W'(size_reg[0]) * PROD2_W'(size_reg[1]);
    assign prod3_next = STRIDE_W'(prod2_reg) * STRIDE_W'(size_reg[2]);
    assign grid_next  = IDX_W'(prod3_reg) * IDX_W'(size_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod2_reg <= PROD2_RESET;
            prod3_reg <= PROD3_RESET;
            grid_reg  <= GRID_RESET;
        end else begin
            prod2_reg <= prod2_next;
            prod3_reg <= prod3_next;
            grid_reg  <= grid_next;
        end
    end

    // Strides and peel selects.
    always_comb begin
        geom.stride[0] = STRIDE_W'(1);
        geom.stride[1] = STRIDE_W'(size_reg[0]);
        geom.stride[2] = STRIDE_W'(prod2_reg);
        geom.stride[3] = prod3_reg;
        geom.grid      = grid_reg;
        for (int p = 0; p < DIMS; p++) begin
            geom.sel[p] = order_reg[p*SEL_W +: SEL_W];
        end
    end

endmodule

// ----- hw/rtl/mru_div_step.sv -----
module mru_div_step
    import mru_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  word_t               in_word,
    input  logic [STRIDE_W-1:0] stride,
    output logic                out_valid,
    output word_t               out_word
);

    logic [STRIDE_W:0] trial;
    logic [STRIDE_W:0] diff;
    logic              ge;
    word_t             word_next;
    logic              valid_reg;
    word_t             word_reg;

    // One restoring step; the dividend rotates so it is whole again after a full pass.
    always_comb begin
        trial     = {in_word.rem, in_word.num[IDX_W-1]};
        ge        = trial >= {1'b0, stride};
        diff      = trial - {1'b0, stride};
        word_next = in_word;
        word_next.num = {in_word.num[IDX_W-2:0], in_word.num[IDX_W-1]};
        word_next.rem = ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
        word_next.quo = {in_word.quo[IDX_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- hw/rtl/mru_divider.sv -----
module mru_divider
    import mru_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  word_t               in_word,
    input  logic [STRIDE_W-1:0] stride,
    output logic                out_valid,
    output word_t               out_word
);

    logic  step_valid [0:IDX_W];
    word_t step_word  [0:IDX_W];
    word_t last;

    // Clear the partial remainder and quotient on entry.
    always_comb begin
        step_word[0]     = in_word;
        step_word[0].rem = '0;
        step_word[0].quo = '0;
    end
    assign step_valid[0] = in_valid;

    for (genvar i = 0; i < IDX_W; i++) begin : g_step
        mru_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (step_valid[i]),
            .in_word   (step_word[i]),
            .stride    (stride),
            .out_valid (step_valid[i+1]),
            .out_word  (step_word[i+1])
        );
    end

    // A zero stride leaves the running value alone; its quotient is already all ones.
    always_comb begin
        last     = step_word[IDX_W];
        out_word = last;
        if (stride != '0) begin
            out_word.num = IDX_W'(last.rem);
        end
        out_word.qlist = {last.qlist[NUM_DIV-2:0], last.quo};
    end
    assign out_valid = step_valid[IDX_W];

endmodule

// ----- hw/rtl/mixed_radix_index_unravel.sv -----
// Path of a word: input register, delay stage, three dividers, output register, m_valid.
// Throughput: one word per cycle; three 32-stage restoring dividers, one bit each stage.
// A stall on the result side freezes the whole pipeline, so nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline and loads extents 16 and the
// identity peel order; derived strides settle through the chained product registers.
module mixed_radix_index_unravel
    import mru_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IDX_W-1:0]     s_linear_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_coord_0,
    output logic [IDX_W-1:0]     m_coord_1,
    output logic [IDX_W-1:0]     m_coord_2,
    output logic [IDX_W-1:0]     m_coord_3,
    output logic                 m_beyond_grid,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    geom_t geom;
    logic  en;
    logic  in_valid_reg, dly_valid_reg;
    word_t in_word_next;
    word_t in_word_reg, dly_word_reg;
    logic  div_valid [0:NUM_DIV];
    word_t div_word  [0:NUM_DIV];
    logic [DIMS-1:0][IDX_W-1:0] coord_next, coord_reg;
    logic  beyond_next, beyond_reg;
    logic  out_valid_reg;

    mru_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // A fresh word carries the index twice: once kept, once as the running dividend.
    always_comb begin
        in_word_next     = '0;
        in_word_next.idx = s_linear_index;
        in_word_next.num = s_linear_index;
    end

    // Input register and one delay stage, which give the strides time to settle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            dly_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_valid;
            dly_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_word_reg  <= in_word_next;
            dly_word_reg <= in_word_reg;
        end
    end

    assign div_valid[0] = dly_valid_reg;
    assign div_word[0]  = dly_word_reg;

    // One divider per peel position except the lowest, highest position first.
    for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
        mru_divider u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[k]),
            .in_word   (div_word[k]),
            .stride    (geom.stride[geom.sel[DIMS-1-k]]),
            .out_valid (div_valid[k+1]),
            .out_word  (div_word[k+1])
        );
    end

    // Place quotients by peel order; a later position overrides an earlier one.
    always_comb begin
        coord_next = '0;
        for (int k = 0; k < NUM_DIV; k++) begin
            coord_next[geom.sel[DIMS-1-k]] = div_word[NUM_DIV].qlist[NUM_DIV-1-k];
        end
        coord_next[geom.sel[0]] = div_word[NUM_DIV].num;
        beyond_next = div_word[NUM_DIV].idx >= geom.grid;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= div_valid[NUM_DIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coord_reg  <= coord_next;
            beyond_reg <= beyond_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_coord_0     = coord_reg[0];
    assign m_coord_1     = coord_reg[1];
    assign m_coord_2     = coord_reg[2];
    assign m_coord_3     = coord_reg[3];
    assign m_beyond_grid = beyond_reg;

endmodule

// ----- hw/rtl/mru_checker.sv -----
module mru_checker
    import mru_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [IDX_W-1:0]     m_coord_0,
    input logic [IDX_W-1:0]     m_coord_1,
    input logic [IDX_W-1:0]     m_coord_2,
    input logic [IDX_W-1:0]     m_coord_3,
    input logic                 m_beyond_grid,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coord_0) && $stable(m_coord_1)
            && $stable(m_coord_2) && $stable(m_coord_3) && $stable(m_beyond_grid))
        else $error("stalled result word changed");

    // Intake follows the output register: taken only when it is free or draining.
    a_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not track the output stall");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind mixed_radix_index_unravel mru_checker u_mru_checker (.*);

// ----- tb/sv/mixed_radix_index_unravel_tb.sv -----
module mixed_radix_index_unravel_tb;
    import mru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the end of the list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam int DRAIN_CYCLES = 110;
    localparam int NUM_PHASES   = 15;
    localparam int PHASE_WORDS  = 33;

    typedef struct packed {
        logic [DIMS-1:0][IDX_W-1:0] coord;
        logic                       beyond;
    } coord_set_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [IDX_W-1:0]     s_linear_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IDX_W-1:0]     m_coord_0;
    logic [IDX_W-1:0]     m_coord_1;
    logic [IDX_W-1:0]     m_coord_2;
    logic [IDX_W-1:0]     m_coord_3;
    logic                 m_beyond_grid;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    // Local copy of the configuration registers.
    logic [SIZE_W-1:0]  extent [DIMS];
    logic [ORDER_W-1:0] peel_sel;

    logic [IDX_W-1:0] index_pending [$];
    coord_set_t       coords_due [$];
    int               src_idle = 22;
    int               snk_idle = 57;
    bit               hold_sender = 1'b0;
    int               errors = 0;

    mixed_radix_index_unravel uut (.*);

    always #5 aclk = ~aclk;

    // Product of all extents, as wide as it can get.
    function automatic longint unsigned grid_size();
        longint unsigned g;
        g = 1;
        for (int d = 0; d < DIMS; d++) g = g * extent[d];
        return g;
    endfunction

    // Peel coordinates off the index by dividing through the chosen strides.
    function automatic coord_set_t unravel(logic [IDX_W-1:0] idx);
        coord_set_t      r;
        longint unsigned stride [DIMS];
        longint unsigned g;
        longint unsigned rest;
        logic [SEL_W-1:0] d;
        g = 1;
        for (int k = 0; k < DIMS; k++) begin
            stride[k] = g;
            g = g * extent[k];
        end
        r = '0;
        rest = idx;
        for (int p = DIMS - 1; p > 0; p--) begin
            d = peel_sel[SEL_W*p +: SEL_W];
            if (stride[d] == 0) begin
                r.coord[d] = '1;
            end else begin
                r.coord[d] = IDX_W'(rest / stride[d]);
                rest = rest % stride[d];
            end
        end
        d = peel_sel[SEL_W-1:0];
        r.coord[d] = IDX_W'(rest);
        r.beyond = (longint'(idx) >= g);
        return r;
    endfunction

    // Sender: keeps valid and the word steady until the handshake.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) coords_due.push_back(unravel(s_linear_index));
            if (!s_valid || s_ready) begin
                if (index_pending.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= src_idle) begin
                    s_valid <= 1'b1;
                    s_linear_index <= index_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        coord_set_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle);
            if (m_valid && m_ready) begin
                if (coords_due.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    want = coords_due.pop_front();
                    if (m_coord_0 !== want.coord[0]) begin
                        $error("coord_0: expected %0d, got %0d", want.coord[0], m_coord_0);
                        errors++;
                    end
                    if (m_coord_1 !== want.coord[1]) begin
                        $error("coord_1: expected %0d, got %0d", want.coord[1], m_coord_1);
                        errors++;
                    end
                    if (m_coord_2 !== want.coord[2]) begin
                        $error("coord_2: expected %0d, got %0d", want.coord[2], m_coord_2);
                        errors++;
                    end
                    if (m_coord_3 !== want.coord[3]) begin
                        $error("coord_3: expected %0d, got %0d", want.coord[3], m_coord_3);
                        errors++;
                    end
                    if (m_beyond_grid !== want.beyond) begin
                        $error("beyond_grid: expected %0b, got %0b", want.beyond,
                               m_beyond_grid);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (index_pending.size() > 0 || s_valid || coords_due.size() > 0)
            @(posedge aclk);
    endtask

    // Writes stay back to back; the caller drops cfg_valid after the last one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (idx < REG_PEEL_ORDER) extent[idx] = value;
        else if (idx == REG_PEEL_ORDER) peel_sel = value;
    endtask

    // Reconfigure only once the pipeline has emptied out.
    task automatic configure(logic [SIZE_W-1:0] e0, logic [SIZE_W-1:0] e1,
                             logic [SIZE_W-1:0] e2, logic [SIZE_W-1:0] e3,
                             logic [ORDER_W-1:0] order);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_DIM_SIZE_0, e0);
        write_reg(REG_DIM_SIZE_1, e1);
        write_reg(REG_DIM_SIZE_2, e2);
        write_reg(REG_DIM_SIZE_3, e3);
        write_reg(REG_PEEL_ORDER, order);
        if ($urandom_range(1)) write_reg(CFG_IDX_SPARE_LO, SIZE_W'($urandom));
        else write_reg(CFG_IDX_SPARE_HI, SIZE_W'($urandom));
        cfg_valid <= 1'b0;
        // Give the derived strides time to follow the registers.
        repeat (4) @(posedge aclk);
    endtask

    // Half of the indices inside the grid, some right at its edge, some anywhere.
    function automatic logic [IDX_W-1:0] pick_index();
        longint unsigned g;
        longint unsigned v;
        g = grid_size();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: begin
                v = g + $urandom_range(2) - 1;
                return (g == 0 || v > 64'hFFFF_FFFF) ? $urandom : IDX_W'(v);
            end
            default: return (g == 0) ? $urandom : IDX_W'($urandom_range(IDX_W'(g - 1)));
        endcase
    endfunction

    task automatic push_edges();
        longint unsigned g;
        g = grid_size();
        index_pending.push_back('0);
        index_pending.push_back('1);
        if (g > 0 && g <= 64'hFFFF_FFFF) begin
            index_pending.push_back(IDX_W'(g - 1));
            index_pending.push_back(IDX_W'(g));
        end
    endtask

    // Stimulus schedule.
    initial begin
        logic [SIZE_W-1:0]  e [DIMS];
        logic [ORDER_W-1:0] order;
        for (int d = 0; d < DIMS; d++) extent[d] = SIZE_RESET;
        peel_sel = ORDER_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry: extremes and alternating bit patterns.
        foreach (index_pending[i]) ;
        index_pending.push_back(32'd1);
        index_pending.push_back(32'd15);
        index_pending.push_back(32'd16);
        index_pending.push_back(32'h5555_5555);
        index_pending.push_back(32'hAAAA_AAAA);
        push_edges();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int d = 0; d < DIMS; d++)
                e[d] = ($urandom_range(4) == 0) ? SIZE_W'($urandom_range(255))
                                                : SIZE_W'($urandom_range(1, 12));
            order = ORDER_W'($urandom);
            case (ph)
                0: begin
                    e = '{8'd255, 8'd255, 8'd255, 8'd255};
                    order = ORDER_RESET;
                end
                1: begin
                    e = '{8'd1, 8'd1, 8'd1, 8'd1};
                    order = ORDER_RESET;
                end
                2: order = 8'b00_01_10_11;     // reversed order
                3: e = '{8'd3, 8'd0, 8'd5, 8'd7}; // one zero extent
                4: order = '0;                 // every position names dimension 0
                5: order = '1;                 // every position names dimension 3
                default: ;
            endcase
            if (ph == 5) begin
                src_idle = 57;
                snk_idle = 22;
            end else if (ph == 10) begin
                src_idle = 0;
                snk_idle = 0;
            end
            configure(e[0], e[1], e[2], e[3], order);
            push_edges();
            for (int i = 0; i < PHASE_WORDS; i++) index_pending.push_back(pick_index());
            // Let the pipeline run dry once before feeding it again.
            if (ph == 7) begin
                while (index_pending.size() > PHASE_WORDS / 2) @(posedge aclk);
                hold_sender = 1'b1;
                while (s_valid || coords_due.size() > 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("mixed_radix_index_unravel_tb: clean");
        end else begin
            $display("mixed_radix_index_unravel_tb: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("mixed_radix_index_unravel_tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mru_pkg.sv
hw/rtl/mru_cfg.sv
hw/rtl/mru_div_step.sv
hw/rtl/mru_divider.sv
hw/rtl/mixed_radix_index_unravel.sv
hw/rtl/mru_checker.sv
tb/sv/mixed_radix_index_unravel_tb.sv
